>>> design/spq_pkg.sv
`default_nettype none

package spq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DEL  = 2'd1,
        S_INS  = 2'd2,
        S_RES  = 2'd3
    } state_t;

    // Command broadcast to every cell for one step.
    typedef struct packed {
        logic del_en;   // delete first entry matching the key tag
        logic pop;      // delete the front entry
        logic ins_en;   // insert key tag/priority in sorted place
    } spq_cmd_t;

endpackage

`default_nettype wire

>>> design/spq_cell.sv
`default_nettype none

module spq_cell #(
    parameter int IDX           = 0,
    parameter int CNT_W         = 5,
    parameter int TAG_BITS      = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  wire                      clk,
    input  wire spq_pkg::spq_cmd_t   cmd,
    input  wire [CNT_W-1:0]          count,
    input  wire [TAG_BITS-1:0]       key_tag,
    input  wire [PRIORITY_BITS-1:0]  key_prio,
    input  wire [TAG_BITS-1:0]       prev_tag,
    input  wire [PRIORITY_BITS-1:0]  prev_prio,
    input  wire                      prev_shift,
    input  wire [TAG_BITS-1:0]       next_tag,
    input  wire [PRIORITY_BITS-1:0]  next_prio,
    input  wire                      hit_in,
    output logic [TAG_BITS-1:0]      tag,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic                     shift_out,
    output logic                     hit_out
);
    import spq_pkg::*;

    logic [TAG_BITS-1:0]      tag_reg, tag_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic                     occ;

    assign occ       = count > CNT_W'(IDX);
    // first tag match at or before this cell
    assign hit_out   = hit_in | (occ && (tag_reg == key_tag));
    // new entry lands here or earlier: this cell moves back (or is free)
    assign shift_out = !occ || (prio_reg > key_prio);

    assign tag  = tag_reg;
    assign prio = prio_reg;

    always_comb
    begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (cmd.pop || (cmd.del_en && hit_out))
        begin
            tag_next  = next_tag;
            prio_next = next_prio;
        end
        else if (cmd.ins_en && shift_out)
        begin
            if (prev_shift)
            begin
                tag_next  = prev_tag;
                prio_next = prev_prio;
            end
            else
            begin
                tag_next  = key_tag;
                prio_next = key_prio;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

endmodule

`default_nettype wire

>>> design/stable_priority_queue.sv
`default_nettype none

// Stable priority queue of process tags, lowest priority value at the front,
// equal priorities kept in arrival order.
// Input stream (s_axis_*): one command per transfer: op, proc_tag,
// new_priority. Output stream (m_axis_*): one result per command: status,
// front tag/priority (the popped entry on a good pop), empty flag, occupancy.
// Each command runs through three internal steps on a row of cells that
// each hold one entry and trade data with their neighbors: a delete step
// (pop or first tag match, entries behind shift forward), an insert step
// (entries behind the insertion point shift back), and a result step that
// loads the output register. A new command is accepted only once the
// sequencer is back in idle, after the result step has loaded the output
// register. The tag search is a first-match chain through the cells.
// Reset empties the queue (count to zero), idles the sequencer and drops
// m_axis_tvalid; entry contents are not cleared. When the receiver stalls,
// the finished result waits in the output register; the next command is
// still accepted and worked through, then held in the result step until the
// output register frees up.
module stable_priority_queue #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TAG_BITS      = 8,
    parameter int PRIORITY_BITS = 8,
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_W   = ((2 + TAG_BITS + PRIORITY_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((2 + TAG_BITS + PRIORITY_BITS + 1 + CNT_W + 7) / 8) * 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    // op, proc_tag, new_priority (from bit 0 up), zero padded
    input  wire [IN_W-1:0]   s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    // status, front_tag, front_priority, queue_empty, occupancy (from bit 0 up)
    output logic [OUT_W-1:0] m_axis_tdata
);
    import spq_pkg::*;

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic [TAG_BITS-1:0]      key_tag_reg, key_tag_next;
    logic [PRIORITY_BITS-1:0] key_prio_reg, key_prio_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     found_reg, found_next;
    status_t                  status_reg, status_next;
    logic [TAG_BITS-1:0]      pop_tag_reg, pop_tag_next;
    logic [PRIORITY_BITS-1:0] pop_prio_reg, pop_prio_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [TAG_BITS-1:0]      out_tag_reg, out_tag_next;
    logic [PRIORITY_BITS-1:0] out_prio_reg, out_prio_next;
    logic                     out_empty_reg, out_empty_next;
    logic [CNT_W-1:0]         out_occ_reg, out_occ_next;

    spq_cmd_t                 cmd;
    logic                     in_xfer, out_free, full, found;

    logic [TAG_BITS-1:0]      cell_tag   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio  [QUEUE_DEPTH];
    logic                     cell_shift [QUEUE_DEPTH];
    logic                     cell_hit   [QUEUE_DEPTH];

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign found    = cmd.pop || (cmd.del_en && cell_hit[QUEUE_DEPTH-1]);

    // ---------------- cell row ----------------
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [TAG_BITS-1:0]      p_tag, n_tag;
        logic [PRIORITY_BITS-1:0] p_prio, n_prio;
        logic                     p_shift, h_in;

        if (i == 0)
        begin : g_first
            assign p_tag   = '0;
            assign p_prio  = '0;
            assign p_shift = 1'b0;
            assign h_in    = 1'b0;
        end
        else
        begin : g_rest
            assign p_tag   = cell_tag[i-1];
            assign p_prio  = cell_prio[i-1];
            assign p_shift = cell_shift[i-1];
            assign h_in    = cell_hit[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign n_tag  = '0;
            assign n_prio = '0;
        end
        else
        begin : g_mid
            assign n_tag  = cell_tag[i+1];
            assign n_prio = cell_prio[i+1];
        end

        spq_cell #(
            .IDX           (i),
            .CNT_W         (CNT_W),
            .TAG_BITS      (TAG_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .key_tag    (key_tag_reg),
            .key_prio   (key_prio_reg),
            .prev_tag   (p_tag),
            .prev_prio  (p_prio),
            .prev_shift (p_shift),
            .next_tag   (n_tag),
            .next_prio  (n_prio),
            .hit_in     (h_in),
            .tag        (cell_tag[i]),
            .prio       (cell_prio[i]),
            .shift_out  (cell_shift[i]),
            .hit_out    (cell_hit[i])
        );
    end

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_axis_tvalid) state_next = S_DEL;
            S_DEL:   state_next = S_INS;
            S_INS:   state_next = S_RES;
            S_RES:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_DEL:
            begin
                cmd.pop    = (op_reg == OP_POP) && (count_reg != '0);
                cmd.del_en = (op_reg == OP_REMOVE) || (op_reg == OP_UPDATE);
            end
            S_INS:
            begin
                cmd.ins_en = ((op_reg == OP_INSERT) || (op_reg == OP_UPDATE)) && !full;
            end
            S_RES:   ;
            default: ;
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb
    begin
        op_next       = op_reg;
        key_tag_next  = key_tag_reg;
        key_prio_next = key_prio_reg;
        count_next    = count_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        pop_tag_next  = pop_tag_reg;
        pop_prio_next = pop_prio_reg;

        if (in_xfer)
        begin
            op_next       = op_t'(s_axis_tdata[1:0]);
            key_tag_next  = s_axis_tdata[2 +: TAG_BITS];
            key_prio_next = s_axis_tdata[2 + TAG_BITS +: PRIORITY_BITS];
        end

        if (state_reg == S_DEL)
        begin
            found_next    = found;
            pop_tag_next  = cell_tag[0];
            pop_prio_next = cell_prio[0];
            if (found)
                count_next = count_reg - CNT_W'(1);
        end

        if (state_reg == S_INS)
        begin
            if (cmd.ins_en)
                count_next = count_reg + CNT_W'(1);
            case (op_reg)
                OP_INSERT: status_next = full ? ST_FULL : ST_OK;
                OP_POP:    status_next = found_reg ? ST_OK : ST_EMPTY;
                OP_REMOVE: status_next = found_reg ? ST_OK : ST_NOT_FOUND;
                OP_UPDATE: status_next = full ? ST_FULL : ST_OK;
                default:   status_next = ST_OK;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_prio_next   = out_prio_reg;
        out_empty_next  = out_empty_reg;
        out_occ_next    = out_occ_reg;

        if (m_axis_tvalid && m_axis_tready)
            out_valid_next = 1'b0;

        if ((state_reg == S_RES) && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_empty_next  = count_reg == '0;
            out_occ_next    = count_reg;
            if ((op_reg == OP_POP) && found_reg)
            begin
                out_tag_next  = pop_tag_reg;
                out_prio_next = pop_prio_reg;
            end
            else if (count_reg != '0)
            begin
                out_tag_next  = cell_tag[0];
                out_prio_next = cell_prio[0];
            end
            else
            begin
                out_tag_next  = '0;
                out_prio_next = '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_occ_reg, out_empty_reg, out_prio_reg,
                                   out_tag_reg, out_status_reg});

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_tag_reg    <= key_tag_next;
        key_prio_reg   <= key_prio_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        pop_tag_reg    <= pop_tag_next;
        pop_prio_reg   <= pop_prio_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_prio_reg   <= out_prio_next;
        out_empty_reg  <= out_empty_next;
        out_occ_reg    <= out_occ_next;
    end

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_DEL))
        else $error("accepted command did not start the delete step");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert step did not grow the count");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_empty_reg == (out_occ_reg == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule

`default_nettype wire

>>> tb/stable_priority_queue_test.sv
`timescale 1ns / 100ps

// Stream test for the stable priority queue.
// Each command transfer is scored against a local copy of the sorted queue.
// Results come back strictly in order, one per command.
module stable_priority_queue_test;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either side
    localparam int DRAIN_CYCLES   = 8;      // tail after the last result

    // Result layout on m_axis_tdata, highest field first.
    typedef struct packed {
        logic [4:0] occupancy;
        logic       queue_empty;
        logic [7:0] front_priority;
        logic [7:0] front_tag;
        status_t    status;
    } spq_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // op, proc_tag, new_priority (from bit 0 up), zero padded
    logic [23:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // status, front_tag, front_priority, queue_empty, occupancy (from bit 0 up)
    logic [23:0] m_axis_tdata;

    // Shared by both sides: when clear, neither sender nor receiver idles.
    bit          idle_on = 1'b1;
    int          fail_count = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    // Local copy of the queue, front at index 0.
    logic [7:0]  q_tags [QUEUE_DEPTH];
    logic [7:0]  q_prios [QUEUE_DEPTH];
    int          held_count = 0;

    spq_result_t expected_results [$];

    always #2 clk = ~clk;

    stable_priority_queue i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ---------------------------------------------------------------
    // Queue predictor
    // ---------------------------------------------------------------

    // First position holding tag, or held_count when absent.
    function automatic int find_tag(logic [7:0] tag);
        for (int i = 0; i < held_count; i++)
        begin
            if (q_tags[i] == tag)
                return i;
        end
        return held_count;
    endfunction

    function automatic void delete_entry(int pos);
        for (int i = pos; i + 1 < held_count; i++)
        begin
            q_tags[i]  = q_tags[i + 1];
            q_prios[i] = q_prios[i + 1];
        end
        held_count--;
    endfunction

    // Sorted insert behind every entry of equal or lower priority value.
    function automatic bit insert_entry(logic [7:0] tag, logic [7:0] prio);
        int pos;
        if (held_count >= QUEUE_DEPTH)
            return 1'b0;
        pos = 0;
        while (pos < held_count && q_prios[pos] <= prio)
            pos++;
        for (int i = held_count; i > pos; i--)
        begin
            q_tags[i]  = q_tags[i - 1];
            q_prios[i] = q_prios[i - 1];
        end
        q_tags[pos]  = tag;
        q_prios[pos] = prio;
        held_count++;
        return 1'b1;
    endfunction

    // Applies one command to the local queue and returns the result it gives.
    function automatic spq_result_t apply_command(op_t op, logic [7:0] tag, logic [7:0] prio);
        spq_result_t r;
        int          pos;
        bit          popped;
        r      = '0;
        popped = 1'b0;
        r.status = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (!insert_entry(tag, prio))
                    r.status = ST_FULL;
            end
            OP_POP:
            begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.front_tag      = q_tags[0];
                    r.front_priority = q_prios[0];
                    popped           = 1'b1;
                    delete_entry(0);
                end
            end
            OP_REMOVE:
            begin
                pos = find_tag(tag);
                if (pos >= held_count)
                    r.status = ST_NOT_FOUND;
                else
                    delete_entry(pos);
            end
            default:
            begin
                // update: drop the old copy if any, then reinsert
                pos = find_tag(tag);
                if (pos < held_count)
                    delete_entry(pos);
                if (!insert_entry(tag, prio))
                    r.status = ST_FULL;
            end
        endcase
        if (!popped && held_count > 0)
        begin
            r.front_tag      = q_tags[0];
            r.front_priority = q_prios[0];
        end
        r.queue_empty = (held_count == 0);
        r.occupancy   = 5'(held_count);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: one command per call, prediction taken on the transfer
    // ---------------------------------------------------------------
    task automatic send_cmd(input op_t op, input logic [7:0] tag, input logic [7:0] prio);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 24'($urandom);   // noise while idle
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, prio, tag, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(apply_command(op, tag, prio));
    endtask

    // ---------------------------------------------------------------
    // Receiver and result check
    // ---------------------------------------------------------------
    function automatic void check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act)
        begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        spq_result_t got;
        spq_result_t exp;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = spq_result_t'(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    $error("result with no command outstanding: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp = expected_results.pop_front();
                    check_field("status", exp.status, got.status);
                    check_field("front_tag", exp.front_tag, got.front_tag);
                    check_field("front_priority", exp.front_priority, got.front_priority);
                    check_field("queue_empty", exp.queue_empty, got.queue_empty);
                    check_field("occupancy", exp.occupancy, got.occupancy);
                end
                // stall drawn per result, counted from this transfer
                stall_left = idle_on ? $urandom_range(0, 15) : 0;
                m_axis_tready <= (stall_left == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= (stall_left == 0);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Pop, remove and update against an empty queue.
    task automatic test_empty_queue();
        send_cmd(OP_POP, 8'h00, 8'h00);
        send_cmd(OP_REMOVE, 8'h05, 8'h00);
        send_cmd(OP_UPDATE, 8'hAA, 8'h80);   // absent tag acts as insert
    endtask

    // Extremes, ties kept in arrival order, duplicate tags, update of a present tag.
    task automatic test_order_and_ties();
        send_cmd(OP_INSERT, 8'hFF, 8'h00);
        send_cmd(OP_INSERT, 8'h00, 8'hFF);
        send_cmd(OP_INSERT, 8'h11, 8'h80);   // ties behind AA
        send_cmd(OP_INSERT, 8'hAA, 8'h80);   // duplicate tag
        send_cmd(OP_REMOVE, 8'hAA, 8'h00);   // first copy goes
        send_cmd(OP_UPDATE, 8'h11, 8'h00);   // lands behind FF
        send_cmd(OP_REMOVE, 8'h42, 8'h00);   // not found
    endtask

    // Fill to the top, then the full-queue cases.
    task automatic test_full_queue();
        while (held_count < QUEUE_DEPTH)
            send_cmd(OP_INSERT, 8'(8'h30 + held_count), 8'(255 - held_count * 17));
        send_cmd(OP_INSERT, 8'h77, 8'h10);   // refused
        send_cmd(OP_UPDATE, 8'h78, 8'h10);   // absent, refused
        send_cmd(OP_UPDATE, q_tags[5], 8'hFF);   // present, always fits
        send_cmd(OP_POP, 8'h00, 8'h00);
    endtask

    // Alternating fill and drain phases with random content;
    // some phases run with no idling on either side.
    task automatic test_random_traffic();
        int         pick;
        op_t        op;
        logic [7:0] tag;
        logic [7:0] prio;
        bit         filling;
        for (int phase = 0; phase < 13; phase++)
        begin
            filling = (phase % 2 == 0);
            idle_on = (phase % 4 != 3);
            for (int n = 0; n < 50; n++)
            begin
                pick = $urandom_range(0, 99);
                if (filling)
                    op = pick < 45 ? OP_INSERT : pick < 75 ? OP_UPDATE :
                         pick < 85 ? OP_POP : OP_REMOVE;
                else
                    op = pick < 45 ? OP_POP : pick < 75 ? OP_REMOVE :
                         pick < 90 ? OP_INSERT : OP_UPDATE;
                // tags: mostly ones held, so remove and update hit
                pick = $urandom_range(0, 99);
                if (pick < 50 && held_count > 0)
                    tag = q_tags[$urandom_range(0, held_count - 1)];
                else if (pick < 80)
                    tag = 8'($urandom_range(0, 15));
                else
                    tag = 8'($urandom_range(0, 255));
                // priorities: narrow range for ties, some extremes
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    prio = 8'($urandom_range(0, 3));
                else if (pick < 50)
                    prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else
                    prio = 8'($urandom_range(0, 255));
                send_cmd(op, tag, prio);
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_queue();
        test_order_and_ties();
        test_full_queue();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
